// ===== hw/rtl/n2a_pkg.sv =====
// Shared types and constants for the number-to-ASCII formatter.
// Used by n2a_cell and number_to_ascii_formatter_core; no dependencies.
`default_nettype none

package n2a_pkg;

  localparam int unsigned BIN_W      = 32;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned HEX_DIGITS = BIN_W / DIGIT_W;
  localparam int unsigned CNT_W      = $clog2(BIN_W + 1);
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CHAR_W     = 8;

  localparam logic [CMD_W-1:0] CMD_UDEC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SDEC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HEX  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPA   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;

  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_ADJ  = 4'd3;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_LOAD,
    CELL_DABBLE,
    CELL_NIBBLE
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_LEAD,
    ST_PREFIX,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/n2a_cell.sv =====
// One digit cell of the conversion chain: double-dabble step, nibble shift, load, clear, hold.
// Depends on n2a_pkg.
`default_nettype none

module n2a_cell (
  input  wire logic                         clk_i,
  input  wire n2a_pkg::cell_ctrl_t          ctrl_i,
  input  wire logic                         bit_i,
  input  wire logic [n2a_pkg::DIGIT_W-1:0]  digit_i,
  input  wire logic [n2a_pkg::DIGIT_W-1:0]  load_i,
  output logic      [n2a_pkg::DIGIT_W-1:0]  digit_o,
  output logic                              bit_o
);

  logic [n2a_pkg::DIGIT_W-1:0] digit_q, digit_d;
  logic [n2a_pkg::DIGIT_W-1:0] adj;

  assign adj = (digit_q >= n2a_pkg::DIGIT_FIVE) ? digit_q + n2a_pkg::DIGIT_ADJ : digit_q;
  assign bit_o   = adj[n2a_pkg::DIGIT_W-1];
  assign digit_o = digit_q;

  always_comb begin
    unique case (ctrl_i.op)
      n2a_pkg::CELL_HOLD:   digit_d = digit_q;
      n2a_pkg::CELL_CLEAR:  digit_d = '0;
      n2a_pkg::CELL_LOAD:   digit_d = load_i;
      n2a_pkg::CELL_DABBLE: digit_d = {adj[n2a_pkg::DIGIT_W-2:0], bit_i};
      n2a_pkg::CELL_NIBBLE: digit_d = digit_i;
      default:              digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/number_to_ascii_formatter_core.sv =====
// Number-to-ASCII formatter: a row of ten digit cells doing double-dabble and text output.
// Depends on n2a_pkg and n2a_cell.
//
// Usage: the request channel (valid_i/stall_o) takes cmd_i and value_i; cmd 0 prints
// unsigned decimal, 1 signed decimal, 2 "0x" plus eight uppercase hex digits, 3 is dropped.
// The result channel (valid_o/stall_i) gives one ASCII character per transfer,
// most significant first, with last_o on the final character of the request.
// Throughput: one request at a time; stall_o is high until its last character is taken.
// Decimal: the request is loaded, then the 32-bit value is shifted through the cell row
// (one binary bit per cycle), then leading zeros are stripped one per cycle (up to 9) and
// the first character is picked, then characters follow at one per cycle when the
// receiver does not stall. Hex: the request is loaded, then 10 characters follow at one
// per cycle when the receiver does not stall. The first character appears on valid_o
// after the conversion and leading-zero stripping (decimal), or in the next cycle after
// the request is taken (hex). While stall_i is high during output, the current character
// and last_o hold and nothing advances. Reset returns the block to idle and drops any
// request in progress; stall_o is low after reset.
`default_nettype none

module number_to_ascii_formatter_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              stall_o,
  input  wire logic [n2a_pkg::CMD_W-1:0]    cmd_i,
  input  wire logic [n2a_pkg::BIN_W-1:0]    value_i,
  output logic                              valid_o,
  input  wire logic                         stall_i,
  output logic      [n2a_pkg::CHAR_W-1:0]   ascii_char_o,
  output logic                              last_o
);

  localparam int unsigned ND = n2a_pkg::NUM_DIGITS;
  localparam int unsigned DW = n2a_pkg::DIGIT_W;

  n2a_pkg::state_e             state_q, state_d;
  logic [n2a_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                        neg_q, neg_d;
  logic                        hex_q, hex_d;
  logic                        pre_q, pre_d;
  logic [n2a_pkg::BIN_W-1:0]   bin_q, bin_d;

  n2a_pkg::cell_ctrl_t         cell_ctrl;
  logic [DW-1:0]               digit_w [ND];
  logic                        carry_w [ND];
  logic [DW*ND-1:0]            load_w;
  logic [DW-1:0]               top;

  logic                        in_acc;
  logic                        out_acc;
  logic                        is_neg;
  logic [n2a_pkg::BIN_W-1:0]   mag;

  assign in_acc  = valid_i && !stall_o;
  assign out_acc = valid_o && !stall_i;
  assign top     = digit_w[ND-1];
  assign is_neg  = (cmd_i == n2a_pkg::CMD_SDEC) && value_i[n2a_pkg::BIN_W-1];
  assign mag     = is_neg ? (n2a_pkg::BIN_W'(0) - value_i) : value_i;
  assign load_w  = {value_i, (DW*ND - n2a_pkg::BIN_W)'(0)};

  for (genvar g = 0; g < ND; g++) begin : g_cell
    logic          bit_in;
    logic [DW-1:0] dig_in;
    if (g == 0) begin : g_first
      assign bit_in = bin_q[n2a_pkg::BIN_W-1];
      assign dig_in = '0;
    end else begin : g_rest
      assign bit_in = carry_w[g-1];
      assign dig_in = digit_w[g-1];
    end
    n2a_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .bit_i   (bit_in),
      .digit_i (dig_in),
      .load_i  (load_w[g*DW +: DW]),
      .digit_o (digit_w[g]),
      .bit_o   (carry_w[g])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    hex_d   = hex_q;
    pre_d   = pre_q;
    bin_d   = bin_q;
    unique case (state_q)
      n2a_pkg::ST_IDLE: begin
        if (in_acc) begin
          neg_d = is_neg;
          pre_d = 1'b0;
          bin_d = mag;
          priority if (cmd_i == n2a_pkg::CMD_HEX) begin
            hex_d   = 1'b1;
            cnt_d   = n2a_pkg::CNT_W'(n2a_pkg::HEX_DIGITS);
            state_d = n2a_pkg::ST_PREFIX;
          end else if (cmd_i != n2a_pkg::CMD_NONE) begin
            hex_d   = 1'b0;
            cnt_d   = n2a_pkg::CNT_W'(n2a_pkg::BIN_W);
            state_d = n2a_pkg::ST_CONVERT;
          end else begin
            state_d = n2a_pkg::ST_IDLE;
          end
        end
      end
      n2a_pkg::ST_CONVERT: begin
        bin_d = {bin_q[n2a_pkg::BIN_W-2:0], 1'b0};
        cnt_d = cnt_q - n2a_pkg::CNT_W'(1);
        if (cnt_q == n2a_pkg::CNT_W'(1)) begin
          cnt_d   = n2a_pkg::CNT_W'(ND);
          state_d = n2a_pkg::ST_LEAD;
        end
      end
      n2a_pkg::ST_LEAD: begin
        if ((top == '0) && (cnt_q != n2a_pkg::CNT_W'(1))) begin
          cnt_d = cnt_q - n2a_pkg::CNT_W'(1);
        end else begin
          state_d = neg_q ? n2a_pkg::ST_PREFIX : n2a_pkg::ST_EMIT;
        end
      end
      n2a_pkg::ST_PREFIX: begin
        if (out_acc) begin
          if (hex_q && !pre_q) begin
            pre_d = 1'b1;
          end else begin
            state_d = n2a_pkg::ST_EMIT;
          end
        end
      end
      n2a_pkg::ST_EMIT: begin
        if (out_acc) begin
          cnt_d = cnt_q - n2a_pkg::CNT_W'(1);
          if (cnt_q == n2a_pkg::CNT_W'(1)) begin
            state_d = n2a_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = n2a_pkg::ST_IDLE;
    endcase
  end

  // Outputs and cell control
  always_comb begin
    stall_o      = (state_q != n2a_pkg::ST_IDLE);
    valid_o      = 1'b0;
    last_o       = 1'b0;
    ascii_char_o = n2a_pkg::CHAR_ZERO;
    cell_ctrl.op = n2a_pkg::CELL_HOLD;
    unique case (state_q)
      n2a_pkg::ST_IDLE: begin
        if (in_acc) begin
          cell_ctrl.op = (cmd_i == n2a_pkg::CMD_HEX) ? n2a_pkg::CELL_LOAD : n2a_pkg::CELL_CLEAR;
        end
      end
      n2a_pkg::ST_CONVERT: begin
        cell_ctrl.op = n2a_pkg::CELL_DABBLE;
      end
      n2a_pkg::ST_LEAD: begin
        if ((top == '0) && (cnt_q != n2a_pkg::CNT_W'(1))) begin
          cell_ctrl.op = n2a_pkg::CELL_NIBBLE;
        end
      end
      n2a_pkg::ST_PREFIX: begin
        valid_o = 1'b1;
        priority if (!hex_q) begin
          ascii_char_o = n2a_pkg::CHAR_MINUS;
        end else if (pre_q) begin
          ascii_char_o = n2a_pkg::CHAR_X;
        end else begin
          ascii_char_o = n2a_pkg::CHAR_ZERO;
        end
      end
      n2a_pkg::ST_EMIT: begin
        valid_o = 1'b1;
        last_o  = (cnt_q == n2a_pkg::CNT_W'(1));
        if (top < n2a_pkg::DIGIT_TEN) begin
          ascii_char_o = n2a_pkg::CHAR_ZERO + n2a_pkg::CHAR_W'(top);
        end else begin
          ascii_char_o = n2a_pkg::CHAR_UPA + n2a_pkg::CHAR_W'(top - n2a_pkg::DIGIT_TEN);
        end
        if (out_acc) begin
          cell_ctrl.op = n2a_pkg::CELL_NIBBLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= n2a_pkg::ST_IDLE;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      hex_q   <= 1'b0;
      pre_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      neg_q   <= neg_d;
      hex_q   <= hex_d;
      pre_q   <= pre_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
  end

  a_last_only_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> (state_q == n2a_pkg::ST_EMIT))
    else $error("last character flagged outside digit output");

  a_last_ends_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i && last_o) |=> (state_q == n2a_pkg::ST_IDLE))
    else $error("request not finished after last character");

  a_emit_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == n2a_pkg::ST_EMIT) |-> (cnt_q != '0))
    else $error("digit count ran out during output");

  a_decimal_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == n2a_pkg::ST_EMIT) && !hex_q) |-> (top < n2a_pkg::DIGIT_TEN))
    else $error("decimal cell holds a value above nine");

  a_char_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == n2a_pkg::ST_EMIT) && valid_o && stall_i) |=> $stable(cnt_q))
    else $error("digit count moved while output stalled");

endmodule

`default_nettype wire
